[design/kci_pkg.sv]
// Shared types and constants for the keyframe colour interpolator.
// No dependencies; every other design file imports this package.
`default_nettype none

package kci_pkg;

  localparam int TIME_W    = 32;
  localparam int KEY_IDX_W = 4;
  localparam int KC_W      = 5;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int COLOR_W   = CH_W * NUM_CH;
  localparam int KC_MIN    = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CRD1,
    ST_CRD2,
    ST_DIV,
    ST_BMUL,
    ST_BADD,
    ST_NFRD,
    ST_NFCOPY,
    ST_OUT
  } kci_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic key_write;
    logic query_load;
    logic scan_first;
    logic scan_shift;
    logic seg_hit;
    logic seg_miss;
    logic col_rd_seg;
    logic col_rd_next;
    logic c1_take;
    logic div_step;
    logic blend_mul;
    logic blend_add;
    logic res_copy;
    logic out_load;
  } kci_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic scan_end;
  } kci_stat_t;

endpackage

`default_nettype wire

[design/kci_if.sv]
// Channel interfaces for the keyframe colour interpolator.
// Depends on kci_pkg for field widths.
`default_nettype none

interface kci_in_if import kci_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [KEY_IDX_W-1:0] key_index;
  logic [TIME_W-1:0]    time_value;
  logic [CH_W-1:0]      red_in;
  logic [CH_W-1:0]      green_in;
  logic [CH_W-1:0]      blue_in;
  logic [CH_W-1:0]      alpha_in;

  modport source (output valid, command, key_index, time_value,
                  red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, command, key_index, time_value,
                  red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface kci_out_if import kci_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic [CH_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                  output ready);
endinterface

`default_nettype wire

[design/kci_ctrl.sv]
// Controller state machine of the keyframe colour interpolator.
// Depends on kci_pkg; drives kci_dp through kci_cmd_t and a shared counter.
`default_nettype none

module kci_ctrl import kci_pkg::*; #(
  parameter int MAX_KEYS      = 16,
  parameter int FRACTION_BITS = 16,
  parameter int CNT_W         = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_command,
  input  wire logic             out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output kci_cmd_t              cmd,
  output logic [CNT_W-1:0]      cnt,
  input  wire kci_stat_t        stat
);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRACTION_BITS - 1);
  localparam logic [CNT_W-1:0] CH_LAST  = CNT_W'(NUM_CH - 1);

  kci_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;

    // drop the result once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_QUERY) begin
            cmd.query_load = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.key_write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // entry cnt-1 is on the read port; cnt 0 only issues the first read
        if (cnt_r == CNT_W'(0)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (cnt_r == CNT_W'(1)) begin
          cmd.scan_first = 1'b1;
          cnt_nxt        = cnt_r + CNT_W'(1);
        end else if (stat.hit) begin
          cmd.seg_hit = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_CRD1;
        end else if (stat.scan_end) begin
          cmd.seg_miss = 1'b1;
          state_nxt    = ST_NFRD;
        end else begin
          cmd.scan_shift = 1'b1;
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
      end
      ST_CRD1: begin
        cmd.col_rd_seg = 1'b1;
        state_nxt      = ST_CRD2;
      end
      ST_CRD2: begin
        cmd.col_rd_next = 1'b1;
        cmd.c1_take     = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_BMUL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_BMUL: begin
        cmd.blend_mul = 1'b1;
        state_nxt     = ST_BADD;
      end
      ST_BADD: begin
        cmd.blend_add = 1'b1;
        if (cnt_r == CH_LAST) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_BMUL;
        end
      end
      ST_NFRD: begin
        cmd.col_rd_seg = 1'b1;
        state_nxt      = ST_NFCOPY;
      end
      ST_NFCOPY: begin
        cmd.res_copy = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;

endmodule

`default_nettype wire

[design/kci_dp.sv]
// Datapath of the keyframe colour interpolator: key tables, segment
// compare, restoring divider and channel blend. Depends on kci_pkg.
`default_nettype none

module kci_dp import kci_pkg::*; #(
  parameter int MAX_KEYS      = 16,
  parameter int FRACTION_BITS = 16,
  parameter int CNT_W         = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [KC_W-1:0]      cfg_wdata,
  input  wire logic [KEY_IDX_W-1:0] key_index,
  input  wire logic [TIME_W-1:0]    time_value,
  input  wire logic [COLOR_W-1:0]   color_in,
  input  wire kci_cmd_t             cmd,
  input  wire logic [CNT_W-1:0]     cnt,
  output kci_stat_t                 stat,
  output logic [COLOR_W-1:0]        color_out
);

  localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NU_W  = IDX_W + 1;
  localparam int PW    = CH_W + 1 + FRACTION_BITS + 1;
  localparam logic signed [PW-1:0] ROUND_BIAS = PW'((64'd1 << FRACTION_BITS) - 64'd1);

  logic [TIME_W-1:0]  time_mem  [MAX_KEYS];
  logic [COLOR_W-1:0] color_mem [MAX_KEYS];

  logic [KC_W-1:0]          kc_r;
  logic [TIME_W-1:0]        t_r, prev_r, time_rd_r;
  logic [COLOR_W-1:0]       col_rd_r, c1_r, res_r, out_r;
  logic                     below0_r;
  logic [IDX_W-1:0]         seg_r;
  logic [TIME_W-1:0]        rem_r, span_r;
  logic [FRACTION_BITS-1:0] q_r;
  logic signed [PW-1:0]     prod_r;

  logic [NU_W-1:0]      n_used;
  logic [IDX_W-1:0]     last_idx;
  logic                 key_ok;
  logic [IDX_W-1:0]     col_addr;
  logic                 col_re;
  logic [TIME_W:0]      r2;
  logic                 r2_ge;
  logic [1:0]           ch;
  logic [CH_W-1:0]      c1_ch, c2_ch;
  logic signed [CH_W:0] diff;
  logic signed [PW-1:0] prod_nxt, adj, shifted;
  logic [CH_W-1:0]      blend_byte;

  // clamp the keyframe count into range
  always_comb begin
    if (int'(kc_r) < KC_MIN) n_used = NU_W'(KC_MIN);
    else if (int'(kc_r) > MAX_KEYS) n_used = NU_W'(MAX_KEYS);
    else n_used = NU_W'(kc_r);
  end
  assign last_idx = IDX_W'(n_used - NU_W'(1));
  assign key_ok   = int'(key_index) < MAX_KEYS;

  always_ff @(posedge clk) begin
    if (!rst_n) kc_r <= KC_W'(KC_MIN);
    else if (cfg_we) kc_r <= cfg_wdata;
  end

  // key tables
  assign col_addr = cmd.col_rd_next ? seg_r + IDX_W'(1) : seg_r;
  assign col_re   = cmd.col_rd_seg | cmd.col_rd_next;

  always_ff @(posedge clk) begin
    if (cmd.key_write && key_ok) begin
      time_mem[IDX_W'(key_index)]  <= time_value;
      color_mem[IDX_W'(key_index)] <= color_in;
    end
    time_rd_r <= time_mem[cnt[IDX_W-1:0]];
    if (col_re) col_rd_r <= color_mem[col_addr];
  end

  // segment search
  assign stat.hit      = (prev_r <= t_r) && (t_r < time_rd_r);
  assign stat.scan_end = (cnt - CNT_W'(1)) == CNT_W'(last_idx);

  always_ff @(posedge clk) begin
    if (cmd.query_load) t_r <= time_value;
    if (cmd.scan_first) begin
      below0_r <= t_r < time_rd_r;
      prev_r   <= time_rd_r;
    end
    if (cmd.scan_shift) prev_r <= time_rd_r;
    if (cmd.seg_hit) seg_r <= IDX_W'(cnt - CNT_W'(2));
    if (cmd.seg_miss) seg_r <= below0_r ? '0 : last_idx;
  end

  // restoring divide, one quotient bit a cycle; remainder stays below span
  assign r2    = {rem_r, 1'b0};
  assign r2_ge = r2 >= {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (cmd.seg_hit) begin
      rem_r  <= t_r - prev_r;
      span_r <= time_rd_r - prev_r;
      q_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= r2_ge ? TIME_W'(r2 - {1'b0, span_r}) : r2[TIME_W-1:0];
      q_r   <= {q_r[FRACTION_BITS-2:0], r2_ge};
    end
  end

  // blend one channel per multiply/add pair; quotient truncates toward zero
  assign ch         = cnt[1:0];
  assign c1_ch      = c1_r[CH_W*ch +: CH_W];
  assign c2_ch      = col_rd_r[CH_W*ch +: CH_W];
  assign diff       = $signed({1'b0, c2_ch}) - $signed({1'b0, c1_ch});
  assign prod_nxt   = PW'(diff) * PW'($signed({1'b0, q_r}));
  assign adj        = prod_r[PW-1] ? prod_r + ROUND_BIAS : prod_r;
  assign shifted    = adj >>> FRACTION_BITS;
  assign blend_byte = c1_ch + shifted[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.c1_take) c1_r <= col_rd_r;
    if (cmd.blend_mul) prod_r <= prod_nxt;
    if (cmd.blend_add) res_r[CH_W*ch +: CH_W] <= blend_byte;
    if (cmd.res_copy) res_r <= col_rd_r;
    if (cmd.out_load) out_r <= res_r;
  end

  assign color_out = out_r;

endmodule

`default_nettype wire

[design/keyframe_color_interpolator.sv]
// Top level of the keyframe colour interpolator.
// Depends on kci_pkg, kci_if, kci_ctrl and kci_dp.
`default_nettype none

// The block keeps a table of up to MAX_KEYS keyframes (32-bit time, RGBA
// colour) and answers colour queries by linear interpolation. A transaction
// with command = write stores one keyframe; it gives no result. A
// transaction with command = query scans the table one entry a cycle
// through the time memory's single read port until it finds the segment
// holding the query time, reads the two end colours, runs a restoring
// divider that yields one of the FRACTION_BITS fraction bits per cycle, and
// blends the four channels through one shared multiplier, a multiply step
// and an add step per channel. A query that matches no segment ends after
// the full scan. A query waits in its final state until the output
// register is free. A new transaction is taken once the result is in the
// output register, even while that result still waits to be taken.
// Write keyframe_count only while idle; it is clamped into 2..MAX_KEYS.
// The key tables are not cleared: never query a segment whose entries were
// not written.
module keyframe_color_interpolator import kci_pkg::*; #(
  parameter int MAX_KEYS      = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  kci_in_if.sink               in_ch,
  kci_out_if.source            out_ch,
  input  wire logic            cfg_we,
  input  wire logic [KC_W-1:0] cfg_wdata
);

  // counter spans the scan (up to MAX_KEYS) and the divide
  localparam int CNT_W = $clog2(MAX_KEYS + FRACTION_BITS + 2) + 1;

  kci_cmd_t           cmd;
  kci_stat_t          stat;
  logic [CNT_W-1:0]   cnt;
  logic [COLOR_W-1:0] color_in;
  logic [COLOR_W-1:0] color_out;

  // pack the keyframe colour R in the low byte, A in the high byte
  assign color_in = {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in};

  kci_ctrl #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRACTION_BITS),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .out_ready  (out_ch.ready),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .cmd        (cmd),
    .cnt        (cnt),
    .stat       (stat)
  );

  kci_dp #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRACTION_BITS),
    .CNT_W         (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .key_index  (in_ch.key_index),
    .time_value (in_ch.time_value),
    .color_in   (color_in),
    .cmd        (cmd),
    .cnt        (cnt),
    .stat       (stat),
    .color_out  (color_out)
  );

  assign out_ch.red_out   = color_out[CH_W*0 +: CH_W];
  assign out_ch.green_out = color_out[CH_W*1 +: CH_W];
  assign out_ch.blue_out  = color_out[CH_W*2 +: CH_W];
  assign out_ch.alpha_out = color_out[CH_W*3 +: CH_W];

  // A query keeps the block busy for at least the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.command == CMD_QUERY |=> !in_ch.ready)
    else $error("query accepted but block ready next cycle");

  // A keyframe write leaves the block ready in the next cycle.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.command == CMD_WRITE |=> in_ch.ready)
    else $error("keyframe write stalled the input");

  // A new result only appears at the end of a busy period.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without a query in progress");

  // A write never raises a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.command == CMD_WRITE |=> !$rose(out_ch.valid))
    else $error("result raised after a keyframe write");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for keyframe_color_interpolator: keyframe writes, colour queries and
// keyframe_count settings, checked against an in-bench interpolation predictor.
// Depends on kci_pkg, kci_if and the design files under design/.
module tb;
  import kci_pkg::*;

  localparam int MAX_KEYS      = 16;
  localparam int FRAC_BITS     = 16;
  // Give the block comfortably more than its worst query before a register write.
  localparam int SETTLE_CYCLES = 80;
  localparam int LIMIT_CYCLES  = 400_000;
  localparam int OPS_PER_PHASE = 40;
  localparam int N_PHASES      = 10;
  localparam int N_DIRECTED    = 23;

  // Colour packed as in the key table: red in 7:0 up to alpha in 31:24.
  typedef logic [COLOR_W-1:0] rgba_t;

  typedef struct packed {
    logic                 command;
    logic [KEY_IDX_W-1:0] key_index;
    logic [TIME_W-1:0]    time_value;
    rgba_t                color;
  } kf_item_t;

  typedef struct packed {
    logic                 command;
    logic [KEY_IDX_W-1:0] key_index;
    logic [TIME_W-1:0]    time_value;
    rgba_t                color;
    logic                 typed;
    rgba_t                typed_color;
  } dir_row_t;

  // Directed rows. Typed colours only where the answer is plain: a keyframe hit exactly, a time
  // before the first or past the last keyframe, or a table with no matching segment.
  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Reset count of two keys: black at 100 rising to white at 200
    '{CMD_WRITE, 4'h0, 32'd100,        32'h0000_0000, 1'b0, 32'h0},
    '{CMD_WRITE, 4'h1, 32'd200,        32'hFFFF_FFFF, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'd0,          32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_QUERY, 4'h0, 32'd100,        32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_QUERY, 4'h5, 32'd150,        32'h1234_5678, 1'b0, 32'h0},
    '{CMD_QUERY, 4'hA, 32'd199,        32'h0000_0000, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'd200,        32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{CMD_QUERY, 4'hF, 32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    // Widest span, channels moving both ways
    '{CMD_WRITE, 4'h0, 32'h0000_0000,  32'h00FF_00FF, 1'b0, 32'h0},
    '{CMD_WRITE, 4'h1, 32'hFFFF_FFFF,  32'hFF00_FF00, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'h0000_0000,  32'h0000_0000, 1'b1, 32'h00FF_00FF},
    '{CMD_QUERY, 4'h0, 32'h0000_0001,  32'h0000_0000, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'h7FFF_FFFF,  32'h0000_0000, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'hFFFF_FFFE,  32'h0000_0000, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'hFFFF_FFFF,  32'h0000_0000, 1'b1, 32'hFF00_FF00},
    // Descending times: nothing matches, so below key 0 gives the first colour
    '{CMD_WRITE, 4'h0, 32'd500,        32'h1122_3344, 1'b0, 32'h0},
    '{CMD_WRITE, 4'h1, 32'd300,        32'hAABB_CCDD, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'd400,        32'h0000_0000, 1'b1, 32'h1122_3344},
    '{CMD_QUERY, 4'h0, 32'd600,        32'h0000_0000, 1'b1, 32'hAABB_CCDD},
    '{CMD_QUERY, 4'h0, 32'd300,        32'h0000_0000, 1'b1, 32'h1122_3344},
    // Span of a single tick
    '{CMD_WRITE, 4'h1, 32'd501,        32'h8080_8080, 1'b0, 32'h0},
    '{CMD_QUERY, 4'h0, 32'd500,        32'h0000_0000, 1'b1, 32'h1122_3344},
    '{CMD_QUERY, 4'h0, 32'd501,        32'h0000_0000, 1'b1, 32'h8080_8080}
  };

  // keyframe_count per phase; -1 picks a random 5-bit value. Clamped values 0, 1, 17 and 31
  // sit among the legal ones.
  localparam int PHASE_COUNTS [N_PHASES] = '{16, 0, 31, -1, 1, 17, -1, 2, -1, 16};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [KC_W-1:0]     cfg_wdata;

  kci_in_if  in_ch ();
  kci_out_if out_ch ();

  // Predictor state
  logic [TIME_W-1:0]   key_time_tbl [MAX_KEYS];
  rgba_t               key_color_tbl [MAX_KEYS];
  logic [KC_W-1:0]     keyframe_count_q;
  rgba_t               expected_colors [$];

  int                  err_count   = 0;
  int                  cycle_count = 0;
  int                  result_count = 0;
  bit                  idle_enable = 1'b1;
  string               ch_names [NUM_CH] = '{"red", "green", "blue", "alpha"};

  keyframe_color_interpolator #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d cycles: %s", cycle_count, msg);
    err_count++;
  endtask

  // Clamp the register into 2..MAX_KEYS as the block does
  function automatic int active_keys();
    int n;
    n = keyframe_count_q;
    if (n < KC_MIN) n = KC_MIN;
    if (n > MAX_KEYS) n = MAX_KEYS;
    return n;
  endfunction

  // Expected colour at query time t: first segment with start <= t < end, Q0.16 fraction from
  // one unsigned division, each channel blended and truncated toward zero.
  function automatic rgba_t predict_color(input logic [TIME_W-1:0] t);
    int          n, i, k, seg;
    logic [63:0] delta, span, frac, sum;
    longint      c1, c2, diff, q, fr;
    rgba_t       res;
    n   = active_keys();
    seg = -1;
    res = '0;
    for (i = 0; i + 1 < n; i++) begin
      if (seg < 0 && key_time_tbl[i] <= t && t < key_time_tbl[i+1]) seg = i;
    end
    if (seg >= 0) begin
      delta = {32'd0, t} - {32'd0, key_time_tbl[seg]};
      span  = {32'd0, key_time_tbl[seg+1]} - {32'd0, key_time_tbl[seg]};
      frac  = (delta << FRAC_BITS) / span;
      fr    = frac;
      for (k = 0; k < NUM_CH; k++) begin
        c1   = key_color_tbl[seg][CH_W*k +: CH_W];
        c2   = key_color_tbl[seg+1][CH_W*k +: CH_W];
        diff = c2 - c1;
        q    = (diff * fr) / (64'sd1 <<< FRAC_BITS);
        sum  = c1 + q;
        res[CH_W*k +: CH_W] = sum[CH_W-1:0];
      end
    end else if (t < key_time_tbl[0]) begin
      res = key_color_tbl[0];
    end else begin
      res = key_color_tbl[n-1];
    end
    return res;
  endfunction

  // Query times that land on, beside and between the keyframes in use, plus open noise
  function automatic logic [TIME_W-1:0] pick_query_time();
    int unsigned       sel;
    int                i, n;
    logic [TIME_W-1:0] lo, hi;
    n   = active_keys();
    sel = $urandom_range(0, 99);
    i   = $urandom_range(0, n - 1);
    if (sel < 25) return key_time_tbl[i];
    if (sel < 35) return key_time_tbl[i] - 1'b1;
    if (sel < 45) return key_time_tbl[i] + 1'b1;
    if (sel < 75) begin
      i  = $urandom_range(0, n - 2);
      lo = key_time_tbl[i];
      hi = key_time_tbl[i+1];
      if (hi > lo) return lo + $urandom_range(0, hi - lo - 1);
      return lo;
    end
    if (sel < 92) return $urandom;
    return sel[0] ? '0 : '1;
  endfunction

  // Present one transaction and hold it until the block takes it. Update the key table on a
  // write; queue the expected colour on a query.
  task automatic send_txn(input kf_item_t it, input bit typed, input rgba_t typed_color);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= it.command;
    in_ch.key_index  <= it.key_index;
    in_ch.time_value <= it.time_value;
    in_ch.red_in     <= it.color[7:0];
    in_ch.green_in   <= it.color[15:8];
    in_ch.blue_in    <= it.color[23:16];
    in_ch.alpha_in   <= it.color[31:24];
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (it.command == CMD_WRITE) begin
      key_time_tbl[it.key_index]  = it.time_value;
      key_color_tbl[it.key_index] = it.color;
    end else begin
      expected_colors.push_back(typed ? typed_color : predict_color(it.time_value));
    end
  endtask

  // Drop valid, drain every expected result, then let the block finish any trailing write
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keyframe_count(input logic [KC_W-1:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    keyframe_count_q = value;
  endtask

  // Result side: check each transaction against the oldest expectation, then decide whether to
  // stall in the next cycle.
  initial begin
    int unsigned stall_left;
    rgba_t       got, want;
    int          k;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.alpha_out, out_ch.blue_out, out_ch.green_out, out_ch.red_out};
        result_count++;
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("result %0d (%h) with no query pending", result_count, got));
        end else begin
          want = expected_colors.pop_front();
          for (k = 0; k < NUM_CH; k++) begin
            if (got[CH_W*k +: CH_W] !== want[CH_W*k +: CH_W])
              report_mismatch($sformatf("result %0d %s: got %0d, expected %0d", result_count,
                              ch_names[k], got[CH_W*k +: CH_W], want[CH_W*k +: CH_W]));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    kf_item_t          it;
    dir_row_t          row;
    logic [TIME_W-1:0] times [MAX_KEYS];
    logic [63:0]       cur, gap_max;
    int                p, r, i, j, mode, count_val;
    bit                down;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_WRITE;
    in_ch.key_index  = '0;
    in_ch.time_value = '0;
    in_ch.red_in     = '0;
    in_ch.green_in   = '0;
    in_ch.blue_in    = '0;
    in_ch.alpha_in   = '0;
    keyframe_count_q = KC_W'(KC_MIN);
    for (i = 0; i < MAX_KEYS; i++) begin
      key_time_tbl[i]  = '0;
      key_color_tbl[i] = '0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset count of two keys; only entries 0 and 1 are read
    for (r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      it  = '{row.command, row.key_index, row.time_value, row.color};
      send_txn(it, row.typed, row.typed_color);
    end

    // Random phases: set the count, rewrite the whole table, then mostly queries with the odd
    // single-entry rewrite. The whole table is always written before a query can read it.
    for (p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) idle_enable = 1'b0;
      count_val = (PHASE_COUNTS[p] < 0) ? $urandom_range(0, 31) : PHASE_COUNTS[p];
      write_keyframe_count(KC_W'(count_val));

      // Mostly ascending times at a random scale; some with repeated times, some unordered
      mode = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: gap_max = 4;
        1: gap_max = 1000;
        2: gap_max = 64'd1 << 20;
        default: gap_max = 64'd1 << 28;
      endcase
      cur = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(0, 1 << 20));
      for (i = 0; i < MAX_KEYS; i++) begin
        if (mode >= 8) begin
          times[i] = $urandom;
        end else begin
          times[i] = (cur > 64'hFFFF_FFFF) ? '1 : cur[31:0];
          if (mode == 7 && $urandom_range(0, 1) == 0) cur = cur;
          else cur = cur + $urandom_range(1, gap_max[31:0]);
        end
      end
      if (mode < 7 && $urandom_range(0, 9) == 0) times[MAX_KEYS-1] = '1;

      down = $urandom_range(0, 1);
      for (j = 0; j < MAX_KEYS; j++) begin
        i  = down ? MAX_KEYS - 1 - j : j;
        it = '{CMD_WRITE, KEY_IDX_W'(i), times[i], rgba_t'($urandom)};
        send_txn(it, 1'b0, '0);
      end

      for (j = 0; j < OPS_PER_PHASE; j++) begin
        if ($urandom_range(0, 99) < 12)
          it = '{CMD_WRITE, KEY_IDX_W'($urandom_range(0, MAX_KEYS - 1)), pick_query_time(),
                 rgba_t'($urandom)};
        else
          it = '{CMD_QUERY, KEY_IDX_W'($urandom), pick_query_time(), rgba_t'($urandom)};
        send_txn(it, 1'b0, '0);
      end
    end

    // Drain and let the tail of the last transaction clear
    settle_block();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/kci_pkg.sv
design/kci_if.sv
design/kci_ctrl.sv
design/kci_dp.sv
design/keyframe_color_interpolator.sv
sim/tb.sv
